/* rtl/core/pid_controller_step_macros.svh */
// Assertion macros for the PID step core: implication checks, same cycle and next cycle.
// Taken in by `include; the bodies are empty when SYNTHESIS is defined.
`ifndef PID_CONTROLLER_STEP_MACROS_SVH
`define PID_CONTROLLER_STEP_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the cycle of the antecedent.
`define PCS_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pcs core check failed");
// The consequent must hold in the cycle after the antecedent.
`define PCS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pcs core check failed");
`else
`define PCS_ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define PCS_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/pcs_pkg.sv */
// Shared types, constants, saturation helpers and the microcode ROM of the PID step core.
// No dependencies; every core module imports this package.
package pcs_pkg;

	localparam int PcW = 5;
	typedef logic [PcW-1:0] pcs_pc_t;

	typedef logic signed [47:0] pcs_q48_t;
	localparam pcs_q48_t Max48 = 48'sh7FFF_FFFF_FFFF;
	localparam pcs_q48_t Min48 = 48'sh8000_0000_0000;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_TARGET   = 3'd0,
		REG_GAIN_P   = 3'd1,
		REG_GAIN_I   = 3'd2,
		REG_GAIN_D   = 3'd3,
		REG_GAIN_OUT = 3'd4
	} pcs_reg_t;

	localparam logic signed [31:0] RstTarget  = 32'sd65536;
	localparam logic signed [31:0] RstGainP   = 32'sd124518;
	localparam logic signed [31:0] RstGainI   = 32'sd655;
	localparam logic signed [31:0] RstGainD   = 32'sd26214;
	localparam logic signed [31:0] RstGainOut = 32'sd65536;

	typedef struct packed {
		logic signed [31:0] target;
		logic signed [31:0] gain_p;
		logic signed [31:0] gain_i;
		logic signed [31:0] gain_d;
		logic signed [31:0] gain_out;
	} pcs_cfg_t;

	// Datapath operations
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LATCH,
		OP_ERR,
		OP_DIF,
		OP_MUL_GO,
		OP_MUL_WB,
		OP_DIV_GO,
		OP_DIV_WB,
		OP_ZDER,
		OP_INTEG,
		OP_SUM,
		OP_EMIT,
		OP_CLRI
	} pcs_op_t;

	// Multiplier operand sources
	typedef enum logic [3:0] {
		SRC_ZERO,
		SRC_ABS_SCALE,
		SRC_GAIN_P,
		SRC_GAIN_I,
		SRC_GAIN_D,
		SRC_GAIN_OUT,
		SRC_ERR,
		SRC_DIF,
		SRC_T0,
		SRC_DT
	} pcs_src_t;

	typedef enum logic [1:0] {
		DST_T0,
		DST_PROP,
		DST_DER
	} pcs_dst_t;

	// Conditions that keep the sequencer on its current step
	typedef enum logic [2:0] {
		H_NONE,
		H_NO_INPUT,
		H_MUL_BUSY,
		H_DIV_BUSY,
		H_OUT_FULL
	} pcs_hold_t;

	typedef enum logic [1:0] {
		J_NEXT,
		J_ALWAYS,
		J_KIND_CLR,
		J_DT_ZERO
	} pcs_jump_t;

	typedef struct packed {
		pcs_op_t   op;
		pcs_src_t  asel;
		pcs_src_t  bsel;
		pcs_dst_t  dst;
		pcs_hold_t hold;
		pcs_jump_t jump;
		pcs_pc_t   target;
	} pcs_ctl_t;

	// Datapath status seen by the sequencer
	typedef struct packed {
		logic mul_busy;
		logic div_busy;
		logic kind_clr;
		logic dt_zero;
	} pcs_dpst_t;

	// Step addresses used as jump targets
	localparam pcs_pc_t PC_IDLE  = 5'd0;
	localparam pcs_pc_t PC_INT   = 5'd12;
	localparam pcs_pc_t PC_CLEAR = 5'd21;

	// Clamp a 50-bit sum to the 48-bit range.
	function automatic pcs_q48_t pcs_sat48(input logic signed [49:0] v);
		pcs_q48_t r;
		if (v[49:47] != {3{v[49]}}) begin
			r = v[49] ? Min48 : Max48;
		end else begin
			r = v[47:0];
		end
		return r;
	endfunction

	function automatic logic [47:0] pcs_mag(input pcs_q48_t v);
		logic [47:0] u;
		u = v;
		if (v[47]) begin
			u = ~u + 48'd1;
		end
		return u;
	endfunction

	// Sign and magnitude back to a saturated 48-bit value.
	function automatic pcs_q48_t pcs_from_mag(input logic [79:0] m, input logic neg);
		pcs_q48_t r;
		if (neg) begin
			if (m >= 80'h8000_0000_0000) begin
				r = Min48;
			end else begin
				r = ~m[47:0] + 48'd1;
			end
		end else begin
			if (m > 80'h7FFF_FFFF_FFFF) begin
				r = Max48;
			end else begin
				r = m[47:0];
			end
		end
		return r;
	endfunction

	function automatic pcs_ctl_t pcs_uop(input pcs_op_t op, input pcs_src_t asel,
		input pcs_src_t bsel, input pcs_dst_t dst, input pcs_hold_t hold,
		input pcs_jump_t jump, input pcs_pc_t target);
		pcs_ctl_t c;
		c.op     = op;
		c.asel   = asel;
		c.bsel   = bsel;
		c.dst    = dst;
		c.hold   = hold;
		c.jump   = jump;
		c.target = target;
		return c;
	endfunction

	// Control program: one word per step.
	function automatic pcs_ctl_t pcs_rom(input pcs_pc_t pc);
		pcs_ctl_t c;
		unique case (pc)
			5'd0:  c = pcs_uop(OP_LATCH, SRC_ZERO, SRC_ZERO, DST_T0, H_NO_INPUT, J_NEXT, PC_IDLE);
			5'd1:  c = pcs_uop(OP_ERR, SRC_ZERO, SRC_ZERO, DST_T0, H_NONE, J_KIND_CLR, PC_CLEAR);
			5'd2:  c = pcs_uop(OP_DIF, SRC_ZERO, SRC_ZERO, DST_T0, H_NONE, J_NEXT, PC_IDLE);
			// proportional: |scale| * gain_p, then * error
			5'd3:  c = pcs_uop(OP_MUL_GO, SRC_ABS_SCALE, SRC_GAIN_P, DST_T0, H_NONE, J_NEXT,
				PC_IDLE);
			5'd4:  c = pcs_uop(OP_MUL_WB, SRC_ZERO, SRC_ZERO, DST_T0, H_MUL_BUSY, J_NEXT, PC_IDLE);
			5'd5:  c = pcs_uop(OP_MUL_GO, SRC_T0, SRC_ERR, DST_T0, H_NONE, J_NEXT, PC_IDLE);
			5'd6:  c = pcs_uop(OP_MUL_WB, SRC_ZERO, SRC_ZERO, DST_PROP, H_MUL_BUSY, J_NEXT,
				PC_IDLE);
			// derivative: skipped (left at zero) when elapsed is zero
			5'd7:  c = pcs_uop(OP_ZDER, SRC_ZERO, SRC_ZERO, DST_T0, H_NONE, J_DT_ZERO, PC_INT);
			5'd8:  c = pcs_uop(OP_MUL_GO, SRC_GAIN_D, SRC_DIF, DST_T0, H_NONE, J_NEXT, PC_IDLE);
			5'd9:  c = pcs_uop(OP_MUL_WB, SRC_ZERO, SRC_ZERO, DST_T0, H_MUL_BUSY, J_NEXT, PC_IDLE);
			5'd10: c = pcs_uop(OP_DIV_GO, SRC_ZERO, SRC_ZERO, DST_T0, H_NONE, J_NEXT, PC_IDLE);
			5'd11: c = pcs_uop(OP_DIV_WB, SRC_ZERO, SRC_ZERO, DST_DER, H_DIV_BUSY, J_NEXT,
				PC_IDLE);
			// integral: gain_i * error * elapsed
			5'd12: c = pcs_uop(OP_MUL_GO, SRC_GAIN_I, SRC_ERR, DST_T0, H_NONE, J_NEXT, PC_IDLE);
			5'd13: c = pcs_uop(OP_MUL_WB, SRC_ZERO, SRC_ZERO, DST_T0, H_MUL_BUSY, J_NEXT, PC_IDLE);
			5'd14: c = pcs_uop(OP_MUL_GO, SRC_T0, SRC_DT, DST_T0, H_NONE, J_NEXT, PC_IDLE);
			5'd15: c = pcs_uop(OP_MUL_WB, SRC_ZERO, SRC_ZERO, DST_T0, H_MUL_BUSY, J_NEXT, PC_IDLE);
			5'd16: c = pcs_uop(OP_INTEG, SRC_ZERO, SRC_ZERO, DST_T0, H_NONE, J_NEXT, PC_IDLE);
			5'd17: c = pcs_uop(OP_SUM, SRC_ZERO, SRC_ZERO, DST_T0, H_NONE, J_NEXT, PC_IDLE);
			5'd18: c = pcs_uop(OP_MUL_GO, SRC_GAIN_OUT, SRC_T0, DST_T0, H_NONE, J_NEXT, PC_IDLE);
			5'd19: c = pcs_uop(OP_MUL_WB, SRC_ZERO, SRC_ZERO, DST_T0, H_MUL_BUSY, J_NEXT, PC_IDLE);
			5'd20: c = pcs_uop(OP_EMIT, SRC_ZERO, SRC_ZERO, DST_T0, H_OUT_FULL, J_ALWAYS, PC_IDLE);
			5'd21: c = pcs_uop(OP_CLRI, SRC_ZERO, SRC_ZERO, DST_T0, H_NONE, J_ALWAYS, PC_IDLE);
			default: c = pcs_uop(OP_NOP, SRC_ZERO, SRC_ZERO, DST_T0, H_NONE, J_ALWAYS, PC_IDLE);
		endcase
		return c;
	endfunction

endpackage

/* rtl/core/pid_controller_step.sv */
// PID step core, Q16.16. A control item gives one result after its transfer; a clear item
// clears the integral and gives no result.
// The work is six passes through the one shared multiplier (issue and write-back included)
// and a pass through the derivative divider, skipped when elapsed is zero; one item is worked
// at a time, so a new item is taken only once the last one is through.
// Reset (arst_n low, asynchronous): registers to their defaults, integral and last error to 0.
`include "pid_controller_step_macros.svh"
module pid_controller_step (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_wdata,
	// item stream in
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [87:0] s_axis_tdata,   // measured[31:0], elapsed[55:32], speed_scale[87:56]
	input  logic [0:0]  s_axis_tuser,   // kind[0]: 0 control step, 1 clear integral
	// result stream out
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // drive[31:0]
	output logic [0:0]  m_axis_tuser    // saturated[0]
);
	import pcs_pkg::*;

	pcs_cfg_t  cfg_q;
	pcs_ctl_t  ctl;
	pcs_dpst_t dpst;
	logic      fire, out_full, emit;

	logic               m_valid_q, m_sat_q;
	logic signed [31:0] m_drive_q;
	logic signed [31:0] dp_drive;
	logic               dp_sat;

	// Configuration registers; write them only while the core is idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target   <= RstTarget;
			cfg_q.gain_p   <= RstGainP;
			cfg_q.gain_i   <= RstGainI;
			cfg_q.gain_d   <= RstGainD;
			cfg_q.gain_out <= RstGainOut;
		end else if (cfg_we) begin
			unique case (pcs_reg_t'(cfg_idx))
				REG_TARGET:   cfg_q.target   <= cfg_wdata;
				REG_GAIN_P:   cfg_q.gain_p   <= cfg_wdata;
				REG_GAIN_I:   cfg_q.gain_i   <= cfg_wdata;
				REG_GAIN_D:   cfg_q.gain_d   <= cfg_wdata;
				REG_GAIN_OUT: cfg_q.gain_out <= cfg_wdata;
				default:      ;  // drop writes to unused indexes
			endcase
		end
	end

	// The latch step is the only step that takes a transfer.
	assign s_axis_tready = (ctl.op == OP_LATCH);

	// Hold the emit step while a finished result still waits downstream.
	assign out_full = m_valid_q && !m_axis_tready;
	assign emit     = fire && (ctl.op == OP_EMIT);

	pcs_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.out_full (out_full),
		.dpst     (dpst),
		.ctl      (ctl),
		.fire     (fire)
	);

	pcs_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.fire           (fire),
		.cfg            (cfg_q),
		.in_kind        (s_axis_tuser[0]),
		.in_measured    (s_axis_tdata[31:0]),
		.in_elapsed     (s_axis_tdata[55:32]),
		.in_speed_scale (s_axis_tdata[87:56]),
		.dpst           (dpst),
		.drive          (dp_drive),
		.saturated      (dp_sat)
	);

	// Output register: load on emit, drop valid once the transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_drive_q <= dp_drive;
			m_sat_q   <= dp_sat;
		end
	end

	assign m_axis_tvalid   = m_valid_q;
	assign m_axis_tdata    = m_drive_q;
	assign m_axis_tuser[0] = m_sat_q;

	// One item in flight: a transfer takes the program off the latch step.
	`PCS_ASSERT_NEXT(a_one_item, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	// The multiplier and divider are never busy together.
	`PCS_ASSERT_IMPLY(a_units_excl, clk, arst_n, dpst.mul_busy, !dpst.div_busy)
	// A clipped drive sits on one of the two rails.
	`PCS_ASSERT_IMPLY(a_sat_rail, clk, arst_n, m_axis_tvalid && m_axis_tuser[0],
		m_axis_tdata == 32'h7FFF_FFFF || m_axis_tdata == 32'h8000_0000)
	// Emit always presents a result on the next cycle.
	`PCS_ASSERT_NEXT(a_emit_shows, clk, arst_n, emit, m_axis_tvalid)

endmodule

/* rtl/core/pcs_mul.sv */
// Shared Q16.16 multiplier: 48x48 magnitudes as four 24x24 partial products, then round/saturate.
// Depends on pcs_pkg.
module pcs_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  pcs_pkg::pcs_q48_t a,
	input  pcs_pkg::pcs_q48_t b,
	output logic              busy,
	output pcs_pkg::pcs_q48_t res
);
	import pcs_pkg::*;

	localparam logic [2:0] LastPp   = 3'd3;
	localparam logic [2:0] LastAcc  = 3'd4;
	localparam logic [2:0] RoundCyc = 3'd5;

	logic [2:0]  cnt_q;
	logic        busy_q;
	logic [47:0] ma_q, mb_q, pp_q;
	logic        neg_q;
	logic [1:0]  sh_q;
	logic [95:0] acc_q;
	pcs_q48_t    res_q;

	logic [23:0] ah, bh;
	logic [47:0] prod;
	logic [95:0] addend, rnd;

	always_comb begin
		ah   = cnt_q[1] ? ma_q[47:24] : ma_q[23:0];
		bh   = cnt_q[0] ? mb_q[47:24] : mb_q[23:0];
		prod = ah * bh;
		case (sh_q)
			2'd0:    addend = {48'd0, pp_q};
			2'd1:    addend = {24'd0, pp_q, 24'd0};
			default: addend = {pp_q, 48'd0};
		endcase
		rnd = acc_q + 96'd32768;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == RoundCyc) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	// Each partial product is registered, then accumulated in the next cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= pcs_mag(a);
			mb_q  <= pcs_mag(b);
			neg_q <= a[47] ^ b[47];
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q <= LastPp) begin
				pp_q <= prod;
				sh_q <= {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
			end
			if (cnt_q != 3'd0 && cnt_q <= LastAcc) begin
				acc_q <= acc_q + addend;
			end
			if (cnt_q == RoundCyc) begin
				res_q <= pcs_from_mag(rnd[95:16], neg_q);
			end
		end
	end

	assign busy = busy_q;
	assign res  = res_q;

endmodule

/* rtl/core/pcs_div.sv */
// Derivative divider: rounded (|num| << 16) / dt, restoring, two quotient bits per cycle.
// Depends on pcs_pkg.
module pcs_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  pcs_pkg::pcs_q48_t num,
	input  logic [23:0]       dt,
	output logic              busy,
	output pcs_pkg::pcs_q48_t res
);
	import pcs_pkg::*;

	localparam logic [5:0] DivIters = 6'd32;

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [63:0] nq_q;
	logic [23:0] rem_q, dv_q;
	logic        neg_q;
	pcs_q48_t    res_q;

	logic [24:0] r1, r2, m1, m2;
	logic        ge1, ge2;

	always_comb begin
		r1  = {rem_q, nq_q[63]};
		ge1 = r1 >= {1'b0, dv_q};
		m1  = ge1 ? r1 - {1'b0, dv_q} : r1;
		r2  = {m1[23:0], nq_q[62]};
		ge2 = r2 >= {1'b0, dv_q};
		m2  = ge2 ? r2 - {1'b0, dv_q} : r2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == DivIters) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 6'd1;
			end
		end
	end

	// Numerator bits shift out the top while quotient bits shift in below.
	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= {pcs_mag(num), 16'd0} + {41'd0, dt[23:1]};
			rem_q <= '0;
			dv_q  <= dt;
			neg_q <= num[47];
		end else if (busy_q) begin
			if (cnt_q == DivIters) begin
				res_q <= pcs_from_mag({16'd0, nq_q}, neg_q);
			end else begin
				nq_q  <= {nq_q[61:0], ge1, ge2};
				rem_q <= m2[23:0];
			end
		end
	end

	assign busy = busy_q;
	assign res  = res_q;

endmodule

/* rtl/core/pcs_dp.sv */
// Datapath of the PID step core: item latch, error, term registers, integral and last error.
// Depends on pcs_pkg, pcs_mul and pcs_div.
module pcs_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pcs_pkg::pcs_ctl_t    ctl,
	input  logic                 fire,
	input  pcs_pkg::pcs_cfg_t    cfg,
	input  logic                 in_kind,
	input  logic signed [31:0]   in_measured,
	input  logic [23:0]          in_elapsed,
	input  logic signed [31:0]   in_speed_scale,
	output pcs_pkg::pcs_dpst_t   dpst,
	output logic signed [31:0]   drive,
	output logic                 saturated
);
	import pcs_pkg::*;

	logic               kind_q;
	logic signed [31:0] meas_q, scale_q;
	logic [23:0]        dt_q;
	logic signed [32:0] err_q, last_err_q;
	logic signed [33:0] dif_q;
	pcs_q48_t           t0_q, prop_q, der_q, integ_q;

	logic     mul_start, div_start, mul_busy, div_busy;
	pcs_q48_t mul_a, mul_b, mul_res, div_res, wb_val;

	function automatic pcs_q48_t opnd(input pcs_src_t s);
		pcs_q48_t v;
		pcs_q48_t sc;
		sc = 48'(scale_q);
		case (s)
			SRC_ABS_SCALE: v = sc[47] ? -sc : sc;
			SRC_GAIN_P:    v = 48'(cfg.gain_p);
			SRC_GAIN_I:    v = 48'(cfg.gain_i);
			SRC_GAIN_D:    v = 48'(cfg.gain_d);
			SRC_GAIN_OUT:  v = 48'(cfg.gain_out);
			SRC_ERR:       v = 48'(err_q);
			SRC_DIF:       v = 48'(dif_q);
			SRC_T0:        v = t0_q;
			SRC_DT:        v = {24'd0, dt_q};
			default:       v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		mul_a     = opnd(ctl.asel);
		mul_b     = opnd(ctl.bsel);
		mul_start = fire && (ctl.op == OP_MUL_GO);
		div_start = fire && (ctl.op == OP_DIV_GO);
		wb_val    = (ctl.op == OP_DIV_WB) ? div_res : mul_res;
	end

	pcs_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.res    (mul_res)
	);

	pcs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (t0_q),
		.dt     (dt_q),
		.busy   (div_busy),
		.res    (div_res)
	);

	// State that survives between items.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q    <= '0;
			last_err_q <= '0;
		end else if (fire) begin
			case (ctl.op)
				OP_INTEG: integ_q    <= pcs_sat48(50'(integ_q) + 50'(t0_q));
				OP_CLRI:  integ_q    <= '0;
				OP_EMIT:  last_err_q <= err_q;
				default:  ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			case (ctl.op)
				OP_LATCH: begin
					kind_q  <= in_kind;
					meas_q  <= in_measured;
					dt_q    <= in_elapsed;
					scale_q <= in_speed_scale;
				end
				OP_ERR:   err_q <= 33'(cfg.target) - 33'(meas_q);
				OP_DIF:   dif_q <= 34'(err_q) - 34'(last_err_q);
				OP_ZDER:  der_q <= '0;
				OP_SUM:   t0_q  <= pcs_sat48(50'(prop_q) + 50'(integ_q) + 50'(der_q));
				OP_MUL_WB, OP_DIV_WB: begin
					case (ctl.dst)
						DST_PROP: prop_q <= wb_val;
						DST_DER:  der_q  <= wb_val;
						default:  t0_q   <= wb_val;
					endcase
				end
				default: ;
			endcase
		end
	end

	// Clip the final product to 32 bits.
	always_comb begin
		if (t0_q > 48'sd2147483647) begin
			drive     = 32'sh7FFF_FFFF;
			saturated = 1'b1;
		end else if (t0_q < -48'sd2147483648) begin
			drive     = 32'sh8000_0000;
			saturated = 1'b1;
		end else begin
			drive     = t0_q[31:0];
			saturated = 1'b0;
		end
	end

	always_comb begin
		dpst.mul_busy = mul_busy;
		dpst.div_busy = div_busy;
		dpst.kind_clr = kind_q;
		dpst.dt_zero  = (dt_q == 24'd0);
	end

endmodule

/* rtl/core/pcs_seq.sv */
// Microcode sequencer: step counter, ROM lookup, hold conditions and conditional jumps.
// Depends on pcs_pkg.
module pcs_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               out_full,
	input  pcs_pkg::pcs_dpst_t dpst,
	output pcs_pkg::pcs_ctl_t  ctl,
	output logic               fire
);
	import pcs_pkg::*;

	pcs_pc_t pc_q, pc_d, pc_inc;
	logic    hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	always_comb begin
		ctl    = pcs_rom(pc_q);
		pc_inc = pc_q + 5'd1;
		unique case (ctl.hold)
			H_NONE:     hold = 1'b0;
			H_NO_INPUT: hold = !in_valid;
			H_MUL_BUSY: hold = dpst.mul_busy;
			H_DIV_BUSY: hold = dpst.div_busy;
			H_OUT_FULL: hold = out_full;
			default:    hold = 1'b0;
		endcase
		fire = !hold;
		if (hold) begin
			pc_d = pc_q;
		end else begin
			unique case (ctl.jump)
				J_NEXT:     pc_d = pc_inc;
				J_ALWAYS:   pc_d = ctl.target;
				J_KIND_CLR: pc_d = dpst.kind_clr ? ctl.target : pc_inc;
				J_DT_ZERO:  pc_d = dpst.dt_zero ? ctl.target : pc_inc;
				default:    pc_d = pc_inc;
			endcase
		end
	end

endmodule
